@@ hw/rtl/gwsa_pkg.sv @@
package gwsa_pkg;

   localparam int CellCountLog2Default = 24;
   localparam int WeightBitsDefault    = 16;
   localparam int CsrAddrBits          = 3;
   localparam int CsrDataBits          = 32;

   // Register indexes of the configuration port
   typedef enum logic [CsrAddrBits-1:0] {
      CSR_PARTICLE_X   = 3'd0,
      CSR_PARTICLE_Y   = 3'd1,
      CSR_PARTICLE_Z   = 3'd2,
      CSR_ACCRETION_R  = 3'd3,
      CSR_BONDI_HOYLE  = 3'd4,
      CSR_CELL_SIZE    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] cell_left_x;
      logic signed [31:0] cell_left_y;
      logic signed [31:0] cell_left_z;
      logic [30:0]        cell_width;
      logic [31:0]        density;
      logic               last_cell;
   } req_type;

   typedef struct packed {
      logic [63:0] weighted_sum;
      logic [39:0] weight_sum;
      logic [24:0] cells_inside;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AXIS,
      S_SQ,
      S_RA2,
      S_KSQ,
      S_DINIT,
      S_DIV,
      S_EXP,
      S_SCALE,
      S_WMUL,
      S_ACC,
      S_DONE
   } st_type;

   // exp(-n) in Q1.16 for integer n
   function automatic logic [16:0] exp_int(input logic [3:0] n);
      logic [16:0] v;
      case (n)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd24109;
         4'd2:    v = 17'd8869;
         4'd3:    v = 17'd3263;
         4'd4:    v = 17'd1200;
         4'd5:    v = 17'd442;
         4'd6:    v = 17'd162;
         4'd7:    v = 17'd60;
         4'd8:    v = 17'd22;
         4'd9:    v = 17'd8;
         4'd10:   v = 17'd3;
         4'd11:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // exp(-a/8), exp(-b/64), exp(-c/512) in Q1.16; sel picks the table
   function automatic logic [16:0] exp_frac(input logic [1:0] sel, input logic [2:0] a);
      logic [16:0] v;
      v = 17'd65536;
      case (sel)
         2'd0: begin
            case (a)
               3'd0: v = 17'd65536;
               3'd1: v = 17'd57835;
               3'd2: v = 17'd51039;
               3'd3: v = 17'd45042;
               3'd4: v = 17'd39750;
               3'd5: v = 17'd35079;
               3'd6: v = 17'd30957;
               default: v = 17'd27319;
            endcase
         end
         2'd1: begin
            case (a)
               3'd0: v = 17'd65536;
               3'd1: v = 17'd64520;
               3'd2: v = 17'd63520;
               3'd3: v = 17'd62535;
               3'd4: v = 17'd61565;
               3'd5: v = 17'd60611;
               3'd6: v = 17'd59671;
               default: v = 17'd58746;
            endcase
         end
         default: begin
            case (a)
               3'd0: v = 17'd65536;
               3'd1: v = 17'd65408;
               3'd2: v = 17'd65280;
               3'd3: v = 17'd65153;
               3'd4: v = 17'd65026;
               3'd5: v = 17'd64899;
               3'd6: v = 17'd64772;
               default: v = 17'd64646;
            endcase
         end
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/gaussian_weighted_sphere_average.sv @@
// Gaussian-weighted average over an accretion sphere. Each transaction on the
// req_ channel is one grid cell; req_stall stays high while it is worked on,
// which is shortest for a cell outside the sphere on the first axis and longest
// for an inside cell. The time is set by the one shared 32x32 multiplier,
// which forms the three squared distances, the squared radii, the three exp
// table products and the density product in turn, and by the 14-step
// restoring divider that finds r2/K^2 to nine fraction bits. A cell marked
// last_cell emits the totals on the rsp_ channel and clears them; the result
// sits in an output register, so the next cell may start while it waits.
module gaussian_weighted_sphere_average #(
   parameter int CELL_COUNT_LOG2 = gwsa_pkg::CellCountLog2Default,
   parameter int WEIGHT_BITS     = gwsa_pkg::WeightBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gwsa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gwsa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [gwsa_pkg::CsrAddrBits-1:0]    csr_addr,
   input  logic [gwsa_pkg::CsrDataBits-1:0]    csr_wr_data
);
   import gwsa_pkg::*;

   localparam int SC_W = 17 + WEIGHT_BITS + 1;
   localparam logic [WEIGHT_BITS-1:0] W_FULL = {WEIGHT_BITS{1'b1}};
   localparam logic [24:0] COUNT_MAX = (CELL_COUNT_LOG2 >= 25) ? 25'h1FFFFFF
                                       : 25'(64'd1 << CELL_COUNT_LOG2);
   localparam int REM_W = 76;

   // configuration registers
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [30:0]        ra_ff, bh_ff, cs_ff;

   st_type            state_ff, state_in;
   req_type           item_ff, item_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [30:0]       dist_ff [3];
   logic [30:0]       dist_in;
   logic              dist_we;
   logic [63:0]       r2_ff, r2_in;
   logic [63:0]       mul_ff;
   logic [31:0]       mul_a, mul_b;
   logic [REM_W-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [12:0]       q_ff, q_in;
   logic [16:0]       w_ff, w_in;
   logic [WEIGHT_BITS-1:0] wfin_ff, wfin_in;
   logic [63:0]       wacc_ff, wacc_in;
   logic [39:0]       tacc_ff, tacc_in;
   logic [24:0]       cacc_ff, cacc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // combinational helpers
   logic signed [33:0] left_s, ppos_s, centre_s, d_s;
   logic [33:0]        absd;
   logic [30:0]        k_sel;
   logic               ge;
   logic [REM_W-1:0]   rem_sub;
   logic [SC_W-1:0]    sc, sc_sh;
   logic [64:0]        wsum;
   logic [40:0]        tsum;
   logic [34:0]        rnd;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         pz_ff <= '0;
         ra_ff <= '0;
         bh_ff <= '0;
         cs_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_PARTICLE_X:  px_ff <= csr_wr_data;
            CSR_PARTICLE_Y:  py_ff <= csr_wr_data;
            CSR_PARTICLE_Z:  pz_ff <= csr_wr_data;
            CSR_ACCRETION_R: ra_ff <= csr_wr_data[30:0];
            CSR_BONDI_HOYLE: bh_ff <= csr_wr_data[30:0];
            CSR_CELL_SIZE:   cs_ff <= csr_wr_data[30:0];
            default: ;
         endcase
      end
   end

   // clamp the kernel radius between a quarter cell and half the accretion radius
   always_comb begin
      if (bh_ff < {2'b0, cs_ff[30:2]})
         k_sel = {2'b0, cs_ff[30:2]};
      else if (bh_ff < {1'b0, ra_ff[30:1]})
         k_sel = bh_ff;
      else
         k_sel = {1'b0, ra_ff[30:1]};
   end

   // axis distance for the axis under the counter
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    begin left_s = 34'(item_ff.cell_left_x); ppos_s = 34'(px_ff); end
         2'd1:    begin left_s = 34'(item_ff.cell_left_y); ppos_s = 34'(py_ff); end
         default: begin left_s = 34'(item_ff.cell_left_z); ppos_s = 34'(pz_ff); end
      endcase
      centre_s = left_s + $signed({4'b0, item_ff.cell_width[30:1]});
      d_s      = centre_s - ppos_s;
      absd     = d_s[33] ? 34'(-d_s) : 34'(d_s);
   end

   // divider step, weight rounding, rescale and saturating sums
   always_comb begin
      ge      = rem_ff >= div_ff;
      rem_sub = rem_ff - div_ff;
      rnd     = {1'b0, mul_ff[33:0]} + 35'd32768;
      sc      = ({{(WEIGHT_BITS+1){1'b0}}, w_ff} << WEIGHT_BITS) + SC_W'(32768);
      sc_sh   = sc >> 16;
      wsum    = {1'b0, wacc_ff} + {1'b0, mul_ff};
      tsum    = {1'b0, tacc_ff} + 41'(wfin_ff);
   end

   // sequencer: next state, multiplier operands and datapath updates
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      dist_in      = absd[30:0];
      dist_we      = 1'b0;
      r2_in        = r2_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      q_in         = q_ff;
      w_in         = w_ff;
      wfin_in      = wfin_ff;
      wacc_in      = wacc_ff;
      tacc_in      = tacc_ff;
      cacc_in      = cacc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;
      req_stall    = state_ff != S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               cnt_in   = '0;
               r2_in    = '0;
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            // drop the cell once any axis distance reaches the radius
            if (absd >= {3'b0, ra_ff}) begin
               state_in = S_DONE;
            end else begin
               dist_we = 1'b1;
               cnt_in  = cnt_ff + 4'd1;
               if (cnt_ff == 4'd2) begin
                  cnt_in   = '0;
                  state_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            // square one axis, add the previous square
            if (cnt_ff != 4'd3) begin
               mul_a = {1'b0, dist_ff[cnt_ff[1:0]]};
               mul_b = {1'b0, dist_ff[cnt_ff[1:0]]};
            end
            if (cnt_ff != 4'd0)
               r2_in = r2_ff + mul_ff;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3)
               state_in = S_RA2;
         end
         S_RA2: begin
            mul_a    = {1'b0, ra_ff};
            mul_b    = {1'b0, ra_ff};
            state_in = S_KSQ;
         end
         S_KSQ: begin
            if (mul_ff > r2_ff) begin
               mul_a    = {1'b0, k_sel};
               mul_b    = {1'b0, k_sel};
               state_in = S_DINIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DINIT: begin
            if (mul_ff == '0) begin
               w_in     = (r2_ff == '0) ? 17'd65536 : 17'd0;
               state_in = S_SCALE;
            end else begin
               rem_in   = REM_W'({r2_ff, 9'b0});
               div_in   = REM_W'({mul_ff, 13'b0});
               q_in     = '0;
               cnt_in   = 4'd13;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one restoring step; the first step flags a quotient beyond range
            if (ge)
               rem_in = rem_sub;
            div_in = div_ff >> 1;
            q_in   = {q_ff[11:0], ge};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd13 && ge) begin
               w_in     = '0;
               state_in = S_SCALE;
            end else if (cnt_ff == 4'd0) begin
               cnt_in = '0;
               if (q_in[12:11] == 2'b11) begin
                  w_in     = '0;
                  state_in = S_SCALE;
               end else begin
                  w_in     = exp_int(q_in[12:9]);
                  state_in = S_EXP;
               end
            end
         end
         S_EXP: begin
            // even counts multiply by a fraction table, odd counts round back
            if (!cnt_ff[0]) begin
               mul_a = {15'b0, w_ff};
               case (cnt_ff[2:1])
                  2'd0:    mul_b = {15'b0, exp_frac(2'd0, q_ff[8:6])};
                  2'd1:    mul_b = {15'b0, exp_frac(2'd1, q_ff[5:3])};
                  default: mul_b = {15'b0, exp_frac(2'd2, q_ff[2:0])};
               endcase
            end else begin
               w_in = rnd[32:16];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5)
               state_in = S_SCALE;
         end
         S_SCALE: begin
            wfin_in  = (sc_sh > SC_W'(W_FULL)) ? W_FULL : sc_sh[WEIGHT_BITS-1:0];
            state_in = S_WMUL;
         end
         S_WMUL: begin
            mul_a    = item_ff.density;
            mul_b    = 32'(wfin_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            wacc_in  = wsum[64] ? '1 : wsum[63:0];
            tacc_in  = tsum[40] ? '1 : tsum[39:0];
            if (cacc_ff < COUNT_MAX)
               cacc_in = cacc_ff + 25'd1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold the last cell until the output register is free
            if (!item_ff.last_cell) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.weighted_sum = wacc_ff;
               rsp_in.weight_sum   = tacc_ff;
               rsp_in.cells_inside = cacc_ff;
               rsp_valid_in        = 1'b1;
               wacc_in             = '0;
               tacc_in             = '0;
               cacc_in             = '0;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wacc_ff      <= '0;
         tacc_ff      <= '0;
         cacc_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wacc_ff      <= wacc_in;
         tacc_ff      <= tacc_in;
         cacc_ff      <= cacc_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      r2_ff   <= r2_in;
      mul_ff  <= mul_a * mul_b;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      q_ff    <= q_in;
      w_ff    <= w_in;
      wfin_ff <= wfin_in;
      rsp_ff  <= rsp_in;
      if (dist_we)
         dist_ff[cnt_ff[1:0]] <= dist_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_AXIS)
      else $error("cell accepted but sequencer did not start");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      cacc_ff <= COUNT_MAX)
      else $error("cell count beyond its limit");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCALE |-> w_ff <= 17'd65536)
      else $error("weight above one before rescale");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> cacc_ff == '0 && tacc_ff == '0)
      else $error("totals not cleared after result");

endmodule
